// File: src/ece_pkg.sv
package ece_pkg;

    // field widths
    localparam int VALUE_BITS = 24;
    localparam int TIME_BITS  = 16;
    localparam int FRAC_BITS  = 16;

    // fraction including the integer one
    localparam int FW      = FRAC_BITS + 1;
    // exponent argument: up to eleven ones
    localparam int XW      = FRAC_BITS + 4;
    // difference end - start
    localparam int DW      = VALUE_BITS + 1;
    // square root radicand and partial remainder
    localparam int RADW    = 2 * FW;
    localparam int RW      = FW + 3;
    // exponent constants and accumulator in Q1.30
    localparam int QBITS   = 30;
    localparam int CW      = QBITS + 1;
    localparam int ONE_INT = 1 << FRAC_BITS;

    localparam logic [FW-1:0]        ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

    // curve selector codes
    localparam logic [3:0] SEL_LINEAR      = 4'd0;
    localparam logic [3:0] SEL_QUAD_IN     = 4'd1;
    localparam logic [3:0] SEL_QUAD_OUT    = 4'd2;
    localparam logic [3:0] SEL_QUAD_INOUT  = 4'd3;
    localparam logic [3:0] SEL_CUBIC_IN    = 4'd4;
    localparam logic [3:0] SEL_CUBIC_OUT   = 4'd5;
    localparam logic [3:0] SEL_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] SEL_EXPO_IN     = 4'd7;
    localparam logic [3:0] SEL_EXPO_OUT    = 4'd8;
    localparam logic [3:0] SEL_EXPO_INOUT  = 4'd9;
    localparam logic [3:0] SEL_CIRC_IN     = 4'd10;
    localparam logic [3:0] SEL_CIRC_OUT    = 4'd11;
    localparam logic [3:0] SEL_CIRC_INOUT  = 4'd12;

    // one beat as it travels down the pipeline
    typedef struct packed {
        logic [3:0]            sel;
        logic [VALUE_BITS-1:0] st;
        logic [VALUE_BITS-1:0] en;
        logic                  done;
        logic                  bad;
        logic                  lo;
        logic [FRAC_BITS-1:0]  p;
        logic [FW-1:0]         sqop;
        logic [XW-1:0]         x;
        logic [DW-1:0]         dabs;
        logic                  neg;
        logic [FW-1:0]         f;
        logic [FW-1:0]         root;
    } item_t;

    // floor square root, used only to build constants
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] w;
        r = '0;
        b = 64'd1 << 62;
        w = v;
        for (int i = 0; i < 32; i++)
        begin
            if (w >= r + b)
            begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-k) in Q1.30
    function automatic logic [CW-1:0] exp_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 2; j <= k; j++)
        begin
            c = isqrt64(c << QBITS);
        end
        return c[CW-1:0];
    endfunction

endpackage

// File: src/ece_div_cell.sv
module ece_div_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             up_vld,
    input  ece_pkg::item_t                   up_item,
    input  logic [ece_pkg::TIME_BITS-1:0]    up_rem,
    input  logic [ece_pkg::FRAC_BITS-1:0]    up_quo,
    input  logic [ece_pkg::TIME_BITS-1:0]    up_du,
    output logic                             dn_vld,
    output ece_pkg::item_t                   dn_item,
    output logic [ece_pkg::TIME_BITS-1:0]    dn_rem,
    output logic [ece_pkg::FRAC_BITS-1:0]    dn_quo,
    output logic [ece_pkg::TIME_BITS-1:0]    dn_du
);

    localparam int T = ece_pkg::TIME_BITS;

    logic                          vld_reg;
    ece_pkg::item_t                item_reg;
    logic [T-1:0]                  rem_reg;
    logic [T-1:0]                  rem_next;
    logic [ece_pkg::FRAC_BITS-1:0] quo_reg;
    logic [ece_pkg::FRAC_BITS-1:0] quo_next;
    logic [T-1:0]                  du_reg;
    logic [T:0]                    rem2;
    logic [T:0]                    diff;
    logic                          ge;

    // one restoring step: shift, trial subtract, keep one quotient bit
    always_comb
    begin
        rem2     = {up_rem, 1'b0};
        diff     = rem2 - {1'b0, up_du};
        ge       = rem2 >= {1'b0, up_du};
        rem_next = ge ? diff[T-1:0] : rem2[T-1:0];
        quo_next = {up_quo[ece_pkg::FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= up_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= up_item;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            du_reg   <= up_du;
        end
    end

    assign dn_vld  = vld_reg;
    assign dn_item = item_reg;
    assign dn_rem  = rem_reg;
    assign dn_quo  = quo_reg;
    assign dn_du   = du_reg;

endmodule

// File: src/ece_sqrt_cell.sv
module ece_sqrt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        up_vld,
    input  ece_pkg::item_t              up_item,
    input  logic [ece_pkg::RADW-1:0]    up_rad,
    input  logic [ece_pkg::RW-1:0]      up_rem,
    input  logic [ece_pkg::FW-1:0]      up_root,
    output logic                        dn_vld,
    output ece_pkg::item_t              dn_item,
    output logic [ece_pkg::RADW-1:0]    dn_rad,
    output logic [ece_pkg::RW-1:0]      dn_rem,
    output logic [ece_pkg::FW-1:0]      dn_root
);

    localparam int RADW = ece_pkg::RADW;
    localparam int RW   = ece_pkg::RW;
    localparam int FW   = ece_pkg::FW;

    logic            vld_reg;
    ece_pkg::item_t  item_reg;
    logic [RADW-1:0] rad_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [FW-1:0]   root_reg;
    logic [FW-1:0]   root_next;
    logic [RW-1:0]   cur;
    logic [RW-1:0]   trial;
    logic            ge;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        cur       = {up_rem[RW-3:0], up_rad[RADW-1:RADW-2]};
        trial     = {1'b0, up_root, 2'b01};
        ge        = cur >= trial;
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {up_root[FW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= up_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= up_item;
            rad_reg  <= {up_rad[RADW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign dn_vld  = vld_reg;
    assign dn_item = item_reg;
    assign dn_rad  = rad_reg;
    assign dn_rem  = rem_reg;
    assign dn_root = root_reg;

endmodule

// File: src/ece_exp_cell.sv
module ece_exp_cell #(
    parameter int K = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      up_vld,
    input  ece_pkg::item_t            up_item,
    input  logic [ece_pkg::CW-1:0]    up_acc,
    output logic                      dn_vld,
    output ece_pkg::item_t            dn_item,
    output logic [ece_pkg::CW-1:0]    dn_acc
);

    localparam int CW    = ece_pkg::CW;
    localparam int PW    = 2 * CW;
    localparam int QBITS = ece_pkg::QBITS;
    localparam logic [CW-1:0] C = ece_pkg::exp_const(K);

    logic           vld_reg;
    ece_pkg::item_t item_reg;
    logic [CW-1:0]  acc_reg;
    logic [CW-1:0]  acc_next;
    logic [PW-1:0]  prod;

    // scale by 2^(-2^-K) when this fraction bit of the argument is set
    always_comb
    begin
        prod     = PW'(up_acc) * PW'(C);
        acc_next = up_item.x[ece_pkg::FRAC_BITS-K] ? prod[QBITS+CW-1:QBITS] : up_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= up_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= up_item;
            acc_reg  <= acc_next;
        end
    end

    assign dn_vld  = vld_reg;
    assign dn_item = item_reg;
    assign dn_acc  = acc_reg;

endmodule

// File: src/easing_curve_evaluator.sv
// Easing curve evaluator: start + (end - start) * f(elapsed / duration).
// Input channel in_valid/in_ready carries func, elapsed, duration, start_value
// and end_value; one beat is taken at each edge where both are high.
// Output channel out_valid/out_ready carries eased_value, done_res, bad_mode;
// every input beat gives exactly one output beat, in order.
// From acceptance to out_valid a beat passes a 16-cell divider chain,
// three curve stages, a 17-cell square root chain, a 16-cell exponent chain
// and three output stages. Throughput is one beat per cycle when not stalled.
// Selector codes 13 to 15 return start_value with bad_mode set; otherwise a zero
// duration or elapsed at or past duration returns end_value with done_res set.
// The whole chain advances together: when out_valid is high and out_ready low,
// every stage holds and in_ready drops in the same cycle; in_ready is high
// whenever the output register is empty or being taken.
// Reset clears all valid bits; no beat is in flight after reset.
module easing_curve_evaluator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [3:0]                              func,
    input  logic [ece_pkg::TIME_BITS-1:0]           elapsed,
    input  logic [ece_pkg::TIME_BITS-1:0]           duration,
    input  logic signed [ece_pkg::VALUE_BITS-1:0]   start_value,
    input  logic signed [ece_pkg::VALUE_BITS-1:0]   end_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ece_pkg::VALUE_BITS-1:0]   eased_value,
    output logic                                    done_res,
    output logic                                    bad_mode
);

    localparam int F     = ece_pkg::FRAC_BITS;
    localparam int T     = ece_pkg::TIME_BITS;
    localparam int VB    = ece_pkg::VALUE_BITS;
    localparam int FW    = ece_pkg::FW;
    localparam int XW    = ece_pkg::XW;
    localparam int DW    = ece_pkg::DW;
    localparam int RADW  = ece_pkg::RADW;
    localparam int RW    = ece_pkg::RW;
    localparam int CW    = ece_pkg::CW;
    localparam int QBITS = ece_pkg::QBITS;
    localparam int MW    = DW + FW;
    localparam int SW    = MW - F + 2;
    localparam logic [FW-1:0] ONE = ece_pkg::ONE;

    logic adv;
    ece_pkg::item_t item0;

    // divider chain
    logic           div_vld  [0:F];
    ece_pkg::item_t div_item [0:F];
    logic [T-1:0]   div_rem  [0:F];
    logic [F-1:0]   div_quo  [0:F];
    logic [T-1:0]   div_du   [0:F];

    // curve stages
    logic           vld_a_reg;
    ece_pkg::item_t item_a_reg;
    ece_pkg::item_t item_a_next;
    logic [FW-1:0]  q_a;
    logic [FW-1:0]  t_a;
    logic [FW:0]    r_w;
    logic [XW-1:0]  p10;
    logic [XW-1:0]  q10;
    logic [XW-1:0]  p20;
    logic [DW-1:0]  d_a;

    logic              vld_b_reg;
    ece_pkg::item_t    item_b_reg;
    logic [2*FW-1:0]   m1;
    logic [FW+1:0]     m1s_reg;

    logic            vld_c_reg;
    ece_pkg::item_t  item_c_reg;
    ece_pkg::item_t  item_c_next;
    logic [RADW-1:0] rad_c_reg;
    logic [FW-1:0]   m1h;
    logic [FW-1:0]   m1q;
    logic [2*FW-1:0] m2;
    logic [FW-1:0]   cube;
    logic [FW-1:0]   cube4;
    logic [FW-1:0]   v_c;

    // square root chain
    logic            sq_vld  [0:FW];
    ece_pkg::item_t  sq_item [0:FW];
    logic [RADW-1:0] sq_rad  [0:FW];
    logic [RW-1:0]   sq_rem  [0:FW];
    logic [FW-1:0]   sq_root [0:FW];

    // exponent chain
    logic           ex_vld  [0:F];
    ece_pkg::item_t ex_item [0:F];
    logic [CW-1:0]  ex_acc  [0:F];

    // output stages
    logic           vld_d_reg;
    ece_pkg::item_t item_d_reg;
    ece_pkg::item_t item_d_next;
    logic [CW-1:0]  acc_sh;
    logic [FW-1:0]  e_val;
    logic [FW:0]    circ_sum;
    logic [FW-1:0]  s_val;

    logic           vld_e_reg;
    ece_pkg::item_t item_e_reg;
    logic [MW-1:0]  mag_e_reg;

    logic           out_vld_reg;
    logic [VB-1:0]  out_val_reg;
    logic [VB-1:0]  out_val_next;
    logic           out_done_reg;
    logic           out_bad_reg;
    logic [MW:0]    rnd;
    logic [SW-1:0]  stx;
    logic [SW-1:0]  stepx;
    logic [SW-1:0]  res;
    logic           over;
    logic           under;

    // whole pipeline moves unless the output beat is stuck
    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // classify the incoming beat
    always_comb
    begin
        item0      = '0;
        item0.sel  = func;
        item0.st   = start_value;
        item0.en   = end_value;
        item0.bad  = func > ece_pkg::SEL_CIRC_INOUT;
        item0.done = !item0.bad && ((duration == '0) || (elapsed >= duration));
    end

    assign div_vld[0]  = in_valid;
    assign div_item[0] = item0;
    assign div_rem[0]  = elapsed;
    assign div_quo[0]  = '0;
    assign div_du[0]   = duration;

    for (genvar i = 0; i < F; i++)
    begin : g_div
        ece_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .up_vld  (div_vld[i]),
            .up_item (div_item[i]),
            .up_rem  (div_rem[i]),
            .up_quo  (div_quo[i]),
            .up_du   (div_du[i]),
            .dn_vld  (div_vld[i+1]),
            .dn_item (div_item[i+1]),
            .dn_rem  (div_rem[i+1]),
            .dn_quo  (div_quo[i+1]),
            .dn_du   (div_du[i+1])
        );
    end

    // stage A: pick square operand, exponent argument, and |end - start|
    always_comb
    begin
        item_a_next    = div_item[F];
        item_a_next.p  = div_quo[F];
        item_a_next.lo = div_quo[F] < ece_pkg::HALF;
        q_a = ONE - {1'b0, div_quo[F]};
        t_a = {div_quo[F], 1'b0};
        r_w = {1'b1, {FW{1'b0}}} - {1'b0, t_a};
        p10 = (XW'(div_quo[F]) << 3) + (XW'(div_quo[F]) << 1);
        q10 = (XW'(q_a) << 3) + (XW'(q_a) << 1);
        p20 = (XW'(div_quo[F]) << 4) + (XW'(div_quo[F]) << 2);

        case (item_a_next.sel)
            ece_pkg::SEL_QUAD_OUT, ece_pkg::SEL_CUBIC_OUT, ece_pkg::SEL_CIRC_OUT:
                item_a_next.sqop = q_a;
            ece_pkg::SEL_QUAD_INOUT, ece_pkg::SEL_CUBIC_INOUT:
                item_a_next.sqop = item_a_next.lo ? {1'b0, div_quo[F]} : q_a;
            ece_pkg::SEL_CIRC_INOUT:
                item_a_next.sqop = item_a_next.lo ? t_a : r_w[FW-1:0];
            default:
                item_a_next.sqop = {1'b0, div_quo[F]};
        endcase

        case (item_a_next.sel)
            ece_pkg::SEL_EXPO_IN:
                item_a_next.x = q10;
            ece_pkg::SEL_EXPO_OUT:
                item_a_next.x = p10;
            ece_pkg::SEL_EXPO_INOUT:
                item_a_next.x = item_a_next.lo ? (XW'(11 * ece_pkg::ONE_INT) - p20)
                                               : (p20 - XW'(9 * ece_pkg::ONE_INT));
            default:
                item_a_next.x = '0;
        endcase

        d_a = {item_a_next.en[VB-1], item_a_next.en} - {item_a_next.st[VB-1], item_a_next.st};
        item_a_next.neg  = d_a[DW-1];
        item_a_next.dabs = d_a[DW-1] ? (~d_a + DW'(1)) : d_a;
    end

    // stage B: square the operand
    assign m1 = item_a_reg.sqop * item_a_reg.sqop;

    // stage C: cube, polynomial curves, circular radicand
    always_comb
    begin
        m1h   = m1s_reg[FW:1];
        m1q   = m1s_reg[FW-1:0];
        m2    = m1h * item_b_reg.sqop;
        cube  = m2[F+FW-1:F];
        cube4 = {cube[FW-3:0], 2'b00};
        v_c   = ONE - m1h;

        item_c_next = item_b_reg;
        case (item_b_reg.sel)
            ece_pkg::SEL_LINEAR:      item_c_next.f = {1'b0, item_b_reg.p};
            ece_pkg::SEL_QUAD_IN:     item_c_next.f = m1h;
            ece_pkg::SEL_QUAD_OUT:    item_c_next.f = ONE - m1h;
            ece_pkg::SEL_QUAD_INOUT:  item_c_next.f = item_b_reg.lo ? m1q : (ONE - m1q);
            ece_pkg::SEL_CUBIC_IN:    item_c_next.f = cube;
            ece_pkg::SEL_CUBIC_OUT:   item_c_next.f = ONE - cube;
            ece_pkg::SEL_CUBIC_INOUT: item_c_next.f = item_b_reg.lo ? cube4 : (ONE - cube4);
            default:                  item_c_next.f = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= div_vld[F];
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_a_reg <= item_a_next;
            item_b_reg <= item_a_reg;
            m1s_reg    <= m1[2*FW-1:F-1];
            item_c_reg <= item_c_next;
            rad_c_reg  <= {1'b0, v_c, {F{1'b0}}};
        end
    end

    assign sq_vld[0]  = vld_c_reg;
    assign sq_item[0] = item_c_reg;
    assign sq_rad[0]  = rad_c_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < FW; i++)
    begin : g_sqrt
        ece_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .up_vld  (sq_vld[i]),
            .up_item (sq_item[i]),
            .up_rad  (sq_rad[i]),
            .up_rem  (sq_rem[i]),
            .up_root (sq_root[i]),
            .dn_vld  (sq_vld[i+1]),
            .dn_item (sq_item[i+1]),
            .dn_rad  (sq_rad[i+1]),
            .dn_rem  (sq_rem[i+1]),
            .dn_root (sq_root[i+1])
        );
    end

    // hand the root along with the beat into the exponent chain
    always_comb
    begin
        ex_item[0]      = sq_item[FW];
        ex_item[0].root = sq_root[FW];
    end

    assign ex_vld[0] = sq_vld[FW];
    assign ex_acc[0] = CW'(1) << QBITS;

    for (genvar k = 1; k <= F; k++)
    begin : g_exp
        ece_exp_cell #(
            .K (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .up_vld  (ex_vld[k-1]),
            .up_item (ex_item[k-1]),
            .up_acc  (ex_acc[k-1]),
            .dn_vld  (ex_vld[k]),
            .dn_item (ex_item[k]),
            .dn_acc  (ex_acc[k])
        );
    end

    // stage D: apply the integer part of the exponent, settle f
    always_comb
    begin
        acc_sh   = ex_acc[F] >> ((QBITS - F) + int'(ex_item[F].x[XW-1:F]));
        e_val    = acc_sh[FW-1:0];
        s_val    = ex_item[F].root;
        circ_sum = ex_item[F].lo ? ({1'b0, ONE} - {1'b0, s_val})
                                 : ({1'b0, ONE} + {1'b0, s_val});

        item_d_next = ex_item[F];
        case (ex_item[F].sel)
            ece_pkg::SEL_EXPO_IN:    item_d_next.f = e_val;
            ece_pkg::SEL_EXPO_OUT:   item_d_next.f = ONE - e_val;
            ece_pkg::SEL_EXPO_INOUT: item_d_next.f = ex_item[F].lo ? e_val : (ONE - e_val);
            ece_pkg::SEL_CIRC_IN:    item_d_next.f = ONE - s_val;
            ece_pkg::SEL_CIRC_OUT:   item_d_next.f = s_val;
            ece_pkg::SEL_CIRC_INOUT: item_d_next.f = circ_sum[FW:1];
            default:                 item_d_next.f = ex_item[F].f;
        endcase
    end

    // stage F: round half away from zero, add to start, saturate
    always_comb
    begin
        rnd   = {1'b0, mag_e_reg} + {{(MW - F + 1){1'b0}}, 1'b1, {(F-1){1'b0}}};
        stx   = {{(SW-VB){item_e_reg.st[VB-1]}}, item_e_reg.st};
        stepx = {1'b0, rnd[MW:F]};
        res   = item_e_reg.neg ? (stx - stepx) : (stx + stepx);
        over  = !res[SW-1] && (|res[SW-2:VB-1]);
        under = res[SW-1] && !(&res[SW-2:VB-1]);

        if (item_e_reg.bad)
        begin
            out_val_next = item_e_reg.st;
        end
        else if (item_e_reg.done)
        begin
            out_val_next = item_e_reg.en;
        end
        else if (over)
        begin
            out_val_next = {1'b0, {(VB-1){1'b1}}};
        end
        else if (under)
        begin
            out_val_next = {1'b1, {(VB-1){1'b0}}};
        end
        else
        begin
            out_val_next = res[VB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg   <= 1'b0;
            vld_e_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_d_reg   <= ex_vld[F];
            vld_e_reg   <= vld_d_reg;
            out_vld_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_d_reg   <= item_d_next;
            item_e_reg   <= item_d_reg;
            mag_e_reg    <= item_d_reg.dabs * item_d_reg.f;
            out_val_reg  <= out_val_next;
            out_done_reg <= item_e_reg.done;
            out_bad_reg  <= item_e_reg.bad;
        end
    end

    assign out_valid   = out_vld_reg;
    assign eased_value = out_val_reg;
    assign done_res    = out_done_reg;
    assign bad_mode    = out_bad_reg;

    // a bad selector never reports completion
    a_bad_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(out_bad_reg && out_done_reg))
        else $error("bad_mode and done_res both set");

    // the settled curve value stays within [0, one]
    a_f_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_d_reg |-> (item_d_reg.f <= ONE))
        else $error("curve value above one");

    // the circular root never exceeds one
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[FW] |-> (sq_root[FW] <= ONE))
        else $error("square root above one");

    // the exponent product only shrinks from its start value
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex_vld[F] |-> (ex_acc[F] <= (CW'(1) << QBITS)))
        else $error("exponent accumulator above one");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY   = 55;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [3:0] func;
    logic [ece_pkg::TIME_BITS-1:0] elapsed;
    logic [ece_pkg::TIME_BITS-1:0] duration;
    logic signed [ece_pkg::VALUE_BITS-1:0] start_value;
    logic signed [ece_pkg::VALUE_BITS-1:0] end_value;
    logic out_valid;
    logic out_ready;
    logic signed [ece_pkg::VALUE_BITS-1:0] eased_value;
    logic done_res;
    logic bad_mode;

    typedef struct packed {
        logic [ece_pkg::VALUE_BITS-1:0] value;
        logic                           done;
        logic                           bad;
    } tween_res_t;

    tween_res_t pending_q[$];
    int  errors;
    int  n_sent;
    int  n_checked;
    int  cycle;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off;
    logic [63:0] exp_tab [1:ece_pkg::FRAC_BITS];

    easing_curve_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .elapsed(elapsed), .duration(duration),
        .start_value(start_value), .end_value(end_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .eased_value(eased_value), .done_res(done_res), .bad_mode(bad_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root by bit pairs
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> ece_pkg::FRAC_BITS;
    endfunction

    function automatic logic [63:0] qcube(input logic [63:0] x);
        return qmul(qmul(x, x), x);
    endfunction

    // 2^-x, x and result in the progress format
    function automatic logic [63:0] pow2_neg(input logic [63:0] x);
        logic [63:0] ipart;
        logic [63:0] fr;
        logic [63:0] acc;
        logic [63:0] sh;
        ipart = x >> ece_pkg::FRAC_BITS;
        fr    = x & ((64'd1 << ece_pkg::FRAC_BITS) - 1);
        acc   = 64'd1 << 30;
        for (int k = 1; k <= ece_pkg::FRAC_BITS; k++)
            if (fr[ece_pkg::FRAC_BITS-k])
                acc = (acc * exp_tab[k]) >> 30;
        sh = 64'(30 - ece_pkg::FRAC_BITS) + ipart;
        return (sh >= 64) ? 64'd0 : (acc >> sh);
    endfunction

    function automatic logic [63:0] circ_root(input logic [63:0] v);
        return floor_sqrt(v << ece_pkg::FRAC_BITS);
    endfunction

    function automatic logic [63:0] curve_fraction(input logic [3:0] sel,
                                                   input logic [63:0] p);
        logic [63:0] one;
        logic [63:0] q;
        logic [63:0] t;
        logic        lo;
        one = 64'd1 << ece_pkg::FRAC_BITS;
        q   = one - p;
        lo  = p < (one >> 1);
        t   = 2 * p;
        case (sel)
            ece_pkg::SEL_QUAD_IN:     return qmul(p, p);
            ece_pkg::SEL_QUAD_OUT:    return one - qmul(q, q);
            ece_pkg::SEL_QUAD_INOUT:  return lo ? ((2 * p * p) >> ece_pkg::FRAC_BITS)
                                                : one - ((2 * q * q) >> ece_pkg::FRAC_BITS);
            ece_pkg::SEL_CUBIC_IN:    return qcube(p);
            ece_pkg::SEL_CUBIC_OUT:   return one - qcube(q);
            ece_pkg::SEL_CUBIC_INOUT: return lo ? 4 * qcube(p) : one - 4 * qcube(q);
            ece_pkg::SEL_EXPO_IN:     return pow2_neg(10 * q);
            ece_pkg::SEL_EXPO_OUT:    return one - pow2_neg(10 * p);
            ece_pkg::SEL_EXPO_INOUT:  return lo ? pow2_neg(11 * one - 20 * p)
                                                : one - pow2_neg(20 * p - 9 * one);
            ece_pkg::SEL_CIRC_IN:     return one - circ_root(one - qmul(p, p));
            ece_pkg::SEL_CIRC_OUT:    return circ_root(one - qmul(q, q));
            ece_pkg::SEL_CIRC_INOUT:
                if (lo)
                    return (one - circ_root(one - qmul(t, t))) >> 1;
                else
                    return (one + circ_root(one - qmul(2 * one - t, 2 * one - t))) >> 1;
            default:                  return p;
        endcase
    endfunction

    function automatic tween_res_t predict_tween(input logic [3:0] sel,
            input logic [ece_pkg::TIME_BITS-1:0] el,
            input logic [ece_pkg::TIME_BITS-1:0] du,
            input logic signed [ece_pkg::VALUE_BITS-1:0] st,
            input logic signed [ece_pkg::VALUE_BITS-1:0] en);
        tween_res_t r;
        longint vmax;
        longint s;
        longint d;
        longint acc;
        logic [63:0] p;
        logic [63:0] f;
        logic [63:0] mag;
        vmax = (longint'(1) << (ece_pkg::VALUE_BITS - 1)) - 1;
        r = '0;
        if (sel > ece_pkg::SEL_CIRC_INOUT)
        begin
            r.value = st;
            r.bad   = 1'b1;
        end
        else if (du == 0 || el >= du)
        begin
            r.value = en;
            r.done  = 1'b1;
        end
        else
        begin
            p = (64'(el) << ece_pkg::FRAC_BITS) / du;
            f = curve_fraction(sel, p);
            s = st;
            d = longint'(en) - s;
            mag = 64'(d < 0 ? -d : d) * f;
            mag = (mag + (64'd1 << (ece_pkg::FRAC_BITS - 1))) >> ece_pkg::FRAC_BITS;
            acc = d < 0 ? s - longint'(mag) : s + longint'(mag);
            if (acc > vmax) acc = vmax;
            if (acc < -vmax - 1) acc = -vmax - 1;
            r.value = acc[ece_pkg::VALUE_BITS-1:0];
        end
        return r;
    endfunction

    // offer one beat and hold it until taken
    task automatic send_tween(input logic [3:0] sel,
            input logic [ece_pkg::TIME_BITS-1:0] el,
            input logic [ece_pkg::TIME_BITS-1:0] du,
            input logic [ece_pkg::VALUE_BITS-1:0] st,
            input logic [ece_pkg::VALUE_BITS-1:0] en);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func        <= sel;
        elapsed     <= el;
        duration    <= du;
        start_value <= st;
        end_value   <= en;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.insert(pending_q.size(), predict_tween(sel, el, du, st, en));
        n_sent++;
    endtask

    task automatic send_random(input int kind);
        logic [ece_pkg::TIME_BITS-1:0] du;
        logic [ece_pkg::TIME_BITS-1:0] el;
        logic [3:0] sel;
        logic [ece_pkg::VALUE_BITS-1:0] st;
        logic [ece_pkg::VALUE_BITS-1:0] en;
        sel = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                       : 4'($urandom_range(12));
        du  = ece_pkg::TIME_BITS'($urandom);
        if ($urandom_range(3) == 0)
            du = ece_pkg::TIME_BITS'($urandom_range(1, 8));
        el  = ($urandom_range(7) == 0) ? ece_pkg::TIME_BITS'($urandom)
                                       : ece_pkg::TIME_BITS'($urandom_range(du));
        st  = ece_pkg::VALUE_BITS'($urandom);
        en  = ece_pkg::VALUE_BITS'($urandom);
        if (kind == 1)
        begin
            st = ece_pkg::VALUE_BITS'(2 ** (ece_pkg::VALUE_BITS - 1));
            en = ece_pkg::VALUE_BITS'(2 ** (ece_pkg::VALUE_BITS - 1) - 1);
            if ($urandom_range(1)) {st, en} = {en, st};
        end
        send_tween(sel, el, du, st, en);
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [ece_pkg::VALUE_BITS-1:0] vmin;
        logic [ece_pkg::VALUE_BITS-1:0] vmax;
        vmin = {1'b1, {(ece_pkg::VALUE_BITS-1){1'b0}}};
        vmax = {1'b0, {(ece_pkg::VALUE_BITS-1){1'b1}}};
        // every curve at one third progress, full swing
        for (int s = ece_pkg::SEL_LINEAR; s <= ece_pkg::SEL_CIRC_INOUT; s++)
            send_tween(4'(s), 16'd1, 16'd3, vmin, vmax);
        // bad selectors, also past the end
        send_tween(4'd13, 16'd5, 16'd0, 24'd100, 24'd200);
        send_tween(4'd14, 16'hFFFF, 16'd1, vmax, vmin);
        send_tween(4'd15, 16'd0, 16'hFFFF, vmin, vmax);
        // completion: zero duration, equal, past
        send_tween(ece_pkg::SEL_LINEAR, 16'd0, 16'd0, 24'd7, vmin);
        send_tween(ece_pkg::SEL_EXPO_IN, 16'hFFFF, 16'hFFFF, vmax, 24'd9);
        send_tween(ece_pkg::SEL_CIRC_OUT, 16'hFFFF, 16'd10, vmin, vmax);
        // progress zero, just short of one, and either side of one half
        send_tween(ece_pkg::SEL_EXPO_IN, 16'd0, 16'hFFFF, vmax, vmin);
        send_tween(ece_pkg::SEL_EXPO_OUT, 16'hFFFE, 16'hFFFF, vmin, vmax);
        send_tween(ece_pkg::SEL_CIRC_INOUT, 16'hFFFE, 16'hFFFF, vmax, vmin);
        send_tween(ece_pkg::SEL_CUBIC_INOUT, 16'h7FFF, 16'hFFFF, 24'hFFFFFF, 24'h0);
        send_tween(ece_pkg::SEL_QUAD_INOUT, 16'h8000, 16'hFFFF, 24'h0, 24'hFFFFFF);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int pcts [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{32, 32}};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = pcts[ph][0];
            recv_stall_pct = pcts[ph][1];
            for (int i = 0; i < 190; i++)
                send_random(i % 9 == 0);
        end
        wait_drained();
    endtask

    // stall output long while offering beats so the pipe backs up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off = 200;
        for (int i = 0; i < 80; i++)
            send_random(0);
        wait_drained();
    endtask

    // receiver: random stalls plus a counted hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each taken beat with the oldest prediction
    always @(posedge clk)
    begin
        tween_res_t want;
        cycle <= cycle + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected beat: eased_value %0d", eased_value);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                n_checked++;
                if (eased_value !== want.value)
                begin
                    $error("eased_value expected %0d actual %0d",
                           $signed(want.value), eased_value);
                    errors++;
                end
                if (done_res !== want.done)
                begin
                    $error("done_res expected %0b actual %0b", want.done, done_res);
                    errors++;
                end
                if (bad_mode !== want.bad)
                begin
                    $error("bad_mode expected %0b actual %0b", want.bad, bad_mode);
                    errors++;
                end
            end
        end
        if (cycle >= MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("[easing_curve_evaluator] ERROR");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        cycle = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        elapsed = '0;
        duration = '0;
        start_value = '0;
        end_value = '0;
        exp_tab[1] = floor_sqrt(64'd1 << 59);
        for (int k = 2; k <= ece_pkg::FRAC_BITS; k++)
            exp_tab[k] = floor_sqrt(exp_tab[k-1] << 30);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        repeat (LATENCY + 10) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            $error("%0d results never arrived", pending_q.size());
            errors++;
        end
        $display("covered %0d tweens over all curves, bad selectors, completion", n_sent);
        $display("and saturation; %0d results checked under idle and stall", n_checked);
        if (errors == 0)
            $display("[easing_curve_evaluator] OK");
        else
            $display("[easing_curve_evaluator] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/ece_pkg.sv
src/ece_div_cell.sv
src/ece_sqrt_cell.sv
src/ece_exp_cell.sv
src/easing_curve_evaluator.sv
verif/testbench.sv
